// ===== sv/upss_pkg.sv =====
// ---------------------------------------------------------------------------
// upss_pkg
// Types and constants for the URL path segment splitter.
// ---------------------------------------------------------------------------
`default_nettype none

package upss_pkg;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;

  localparam int unsigned SEG_INDEX_W = 16;
  localparam logic [SEG_INDEX_W-1:0] SEG_INDEX_MAX = '1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] ch;
    logic       url_end;
  } char_word_t;

  typedef struct packed {
    logic [7:0]             seg_byte;
    logic [SEG_INDEX_W-1:0] seg_index;
    logic                   seg_first;
    logic                   seg_last;
  } seg_word_t;

endpackage

`default_nettype wire

// ===== sv/url_path_segment_splitter_unit.sv =====
// ---------------------------------------------------------------------------
// url_path_segment_splitter_unit
// Splits a URL byte stream into path segment bytes with segment index and
// first/last flags; one held byte gives the lookahead for the last flag.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              word
//  char     in   char_valid/char_stall  ch, url_end
//  seg      out  seg_valid/seg_stall    seg_byte, seg_index, seg_first, seg_last
//
//  One character is taken per cycle while char_stall is low; its 0..2
//  segment words land in a 4-entry output queue in the same edge and leave
//  one per cycle while seg_stall is low. char_stall rises while fewer than two
//  queue entries are free, so a run of two-word characters is not taken every cycle.
//  rst (synchronous) empties the queue and returns the parser to seeking '/'.
`default_nettype none

module url_path_segment_splitter_unit (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     char_valid,
  output logic                    char_stall,
  input  upss_pkg::char_word_t    char_word,
  output logic                    seg_valid,
  input  wire                     seg_stall,
  output upss_pkg::seg_word_t     seg_word
);
  import upss_pkg::*;

  localparam logic [2:0] PH_SEEK        = 3'd0;
  localparam logic [2:0] PH_AFTER_SLASH = 3'd1;
  localparam logic [2:0] PH_AUTHORITY   = 3'd2;
  localparam logic [2:0] PH_PATH        = 3'd3;
  localparam logic [2:0] PH_DONE        = 3'd4;

  localparam int unsigned CNT_W = QUEUE_AW + 1;

  logic [2:0]             phase, phase_next;
  logic [7:0]             held_byte, held_byte_next;
  logic                   held_valid, held_valid_next;
  logic                   held_is_first, held_is_first_next;
  logic [SEG_INDEX_W-1:0] segment_count, segment_count_next;

  seg_word_t              queue [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]    wr_ptr, rd_ptr;
  logic [CNT_W-1:0]       count;

  logic       take, give;
  logic       is_slash, is_mark, go_path;
  logic [7:0] mid_byte;
  logic       mid_valid, mid_first;
  logic [SEG_INDEX_W-1:0] mid_count;
  logic       r0_valid, r1_valid;
  seg_word_t  r0, r1;
  logic [CNT_W-1:0] push_n;

  assign char_stall = (count > CNT_W'(QUEUE_DEPTH - 2));
  assign take       = char_valid && !char_stall;
  assign seg_valid  = (count != '0);
  assign give       = seg_valid && !seg_stall;
  assign seg_word   = queue[rd_ptr];

  assign is_slash = (char_word.ch == CH_SLASH);
  assign is_mark  = (char_word.ch == CH_QUERY) || (char_word.ch == CH_HASH);
  assign go_path  = (phase == PH_PATH) || ((phase == PH_AFTER_SLASH) && !is_slash);

  always_comb begin
    phase_next = phase;
    mid_byte   = held_byte;
    mid_valid  = held_valid;
    mid_first  = held_is_first;
    mid_count  = segment_count;

    r0_valid = go_path && held_valid;
    r0.seg_byte  = held_byte;
    r0.seg_index = segment_count;
    r0.seg_first = held_is_first;
    r0.seg_last  = is_mark || is_slash;

    case (phase)
      PH_SEEK: begin
        if (is_slash) phase_next = PH_AFTER_SLASH;
      end
      PH_AFTER_SLASH: begin
        phase_next = is_slash ? PH_AUTHORITY : PH_PATH;
      end
      PH_AUTHORITY: begin
        if (is_slash) phase_next = PH_PATH;
      end
      default: ;
    endcase

    if (go_path) begin
      if (is_mark) begin
        mid_valid  = 1'b0;
        phase_next = PH_DONE;
      end else if (is_slash) begin
        mid_valid = 1'b0;
      end else if (held_valid) begin
        mid_byte  = char_word.ch;
        mid_first = 1'b0;
      end else begin
        if (segment_count != SEG_INDEX_MAX) mid_count = segment_count + 1'b1;
        mid_byte  = char_word.ch;
        mid_first = 1'b1;
        mid_valid = 1'b1;
      end
    end

    r1_valid = char_word.url_end && mid_valid;
    r1.seg_byte  = mid_byte;
    r1.seg_index = mid_count;
    r1.seg_first = mid_first;
    r1.seg_last  = 1'b1;

    if (char_word.url_end) begin
      phase_next         = PH_SEEK;
      held_byte_next     = '0;
      held_valid_next    = 1'b0;
      held_is_first_next = 1'b0;
      segment_count_next = '0;
    end else begin
      held_byte_next     = mid_byte;
      held_valid_next    = mid_valid;
      held_is_first_next = mid_first;
      segment_count_next = mid_count;
    end

    push_n = take ? (CNT_W'(r0_valid) + CNT_W'(r1_valid)) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEEK;
      held_byte     <= '0;
      held_valid    <= 1'b0;
      held_is_first <= 1'b0;
      segment_count <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        held_byte     <= held_byte_next;
        held_valid    <= held_valid_next;
        held_is_first <= held_is_first_next;
        segment_count <= segment_count_next;
      end
      wr_ptr <= wr_ptr + push_n[QUEUE_AW-1:0];
      if (give) rd_ptr <= rd_ptr + 1'b1;
      count <= count + push_n - CNT_W'(give);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (r0_valid) begin
        queue[wr_ptr] <= r0;
        if (r1_valid) queue[wr_ptr + 1'b1] <= r1;
      end else if (r1_valid) begin
        queue[wr_ptr] <= r1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_index_nonzero: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> seg_word.seg_index != '0)
    else $error("segment word with zero index");

  a_held_has_count: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> segment_count != '0)
    else $error("held byte without open segment");

  a_url_end_clears: assert property (@(posedge clk) disable iff (rst)
    take && char_word.url_end |=> !held_valid && segment_count == '0 && phase == PH_SEEK)
    else $error("state not cleared after end of URL");
`endif

endmodule

`default_nettype wire
